// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the frame receiver RTL; clocked on clk,
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/slcfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcfr_pkg
// Constants, types and the CRC-8 step for the sync/length/CRC frame receiver.
// ----------------------------------------------------------------------------
package slcfr_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W     = 6;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_TOP     = 8'h80;
  localparam logic [7:0] CRC_INIT    = 8'h00;

  localparam logic [LEN_W-1:0] EXP_LEN_RESET = LEN_W'(13);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRC   = 3'd4
  } phase_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } slcfr_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } slcfr_rd_t;

  typedef struct packed {
    logic             go;
    logic [LEN_W-1:0] len;
  } slcfr_start_t;

  // One byte through the CRC-8, MSB first.
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/slcfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcfr_if
// Valid/ready channels: received bytes in, payload bytes out.
// ----------------------------------------------------------------------------
interface slcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  payload_byte;
  logic [slcfr_pkg::IDX_W-1:0] byte_index;
  logic                        last_byte;

  modport source (output valid, output payload_byte, output byte_index,
                  output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input byte_index,
                  input last_byte, output ready);
endinterface

// File: design/slcfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcfr_ram
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slcfr_ram (
  input  logic                 clk,
  input  slcfr_pkg::slcfr_wr_t wr,
  input  slcfr_pkg::slcfr_rd_t rd,
  output logic [7:0]           rdata
);

  logic [7:0] mem [slcfr_pkg::BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // rdata holds between reads
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

// File: design/slcfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcfr_parser
// Sync hunt, length check, payload capture and running CRC-8.
// ----------------------------------------------------------------------------
module slcfr_parser (
  input  logic                          clk,
  input  logic                          rst,
  slcfr_in_if.sink                      byte_ch,
  input  logic [slcfr_pkg::LEN_W-1:0]   expected_length,
  input  logic                          drain_busy,
  output slcfr_pkg::slcfr_wr_t          wr,
  output slcfr_pkg::slcfr_start_t       start
);

  localparam logic [7:0] DEPTH_B = 8'(slcfr_pkg::BUF_DEPTH);
  localparam logic [slcfr_pkg::LEN_W-1:0] DEPTH_L = slcfr_pkg::LEN_W'(slcfr_pkg::BUF_DEPTH);

  slcfr_pkg::phase_t phase, phase_next;
  logic [slcfr_pkg::LEN_W-1:0] frame_length;
  logic [slcfr_pkg::LEN_W-1:0] fill_index;
  logic [7:0]                  running_crc;

  logic       acc;
  logic [7:0] b;
  logic       len_ok;
  logic       frame_ok;
  logic [slcfr_pkg::LEN_W-1:0] fill_inc;

  // buffer is off limits while a drain reads it
  assign byte_ch.ready = !drain_busy;
  assign acc      = byte_ch.valid && byte_ch.ready;
  assign b        = byte_ch.rx_byte;
  assign len_ok   = (b != 8'h00) && (b <= DEPTH_B);
  assign frame_ok = (b == running_crc) && (frame_length == expected_length);
  assign fill_inc = fill_index + slcfr_pkg::LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= slcfr_pkg::PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      slcfr_pkg::PH_SYNC2: begin
        if (acc) phase_next = (b == slcfr_pkg::SYNC_SECOND) ? slcfr_pkg::PH_LEN
                                                            : slcfr_pkg::PH_HUNT;
      end
      slcfr_pkg::PH_LEN: begin
        if (acc) phase_next = len_ok ? slcfr_pkg::PH_DATA : slcfr_pkg::PH_HUNT;
      end
      slcfr_pkg::PH_DATA: begin
        if (acc && (fill_inc >= frame_length)) phase_next = slcfr_pkg::PH_CRC;
      end
      slcfr_pkg::PH_CRC: begin
        if (acc) phase_next = slcfr_pkg::PH_HUNT;
      end
      default: begin
        if (acc) phase_next = (b == slcfr_pkg::SYNC_FIRST) ? slcfr_pkg::PH_SYNC2
                                                           : slcfr_pkg::PH_HUNT;
      end
    endcase
  end

  always_comb begin
    wr.en     = 1'b0;
    wr.addr   = fill_index[slcfr_pkg::ADDR_W-1:0];
    wr.data   = b;
    start.go  = 1'b0;
    start.len = frame_length;
    unique case (phase)
      slcfr_pkg::PH_DATA: wr.en    = acc && (fill_index < DEPTH_L);
      slcfr_pkg::PH_CRC:  start.go = acc && frame_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
      fill_index   <= '0;
      running_crc  <= slcfr_pkg::CRC_INIT;
    end else if (acc) begin
      if (phase == slcfr_pkg::PH_LEN) begin
        frame_length <= b[slcfr_pkg::LEN_W-1:0];
        fill_index   <= '0;
        running_crc  <= slcfr_pkg::CRC_INIT;
      end else if (phase == slcfr_pkg::PH_DATA) begin
        fill_index  <= fill_inc;
        running_crc <= slcfr_pkg::crc_update(running_crc, b);
      end
    end
  end

endmodule

// File: design/slcfr_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcfr_drain
// Reads an accepted payload out of the buffer into the output register.
// ----------------------------------------------------------------------------
module slcfr_drain (
  input  logic                    clk,
  input  logic                    rst,
  input  slcfr_pkg::slcfr_start_t start,
  input  logic [7:0]              rdata,
  output slcfr_pkg::slcfr_rd_t    rd,
  output logic                    busy,
  slcfr_out_if.source             payload_ch
);

  logic [slcfr_pkg::LEN_W-1:0]  remaining;
  logic [slcfr_pkg::ADDR_W-1:0] rd_idx;
  logic                         rd_pending;
  logic [slcfr_pkg::IDX_W-1:0]  data_idx;
  logic                         data_last;
  logic                         out_valid;
  logic                         load;
  logic                         issue;

  // rd_pending: rdata holds an entry not yet moved to the output register
  assign busy  = (remaining != '0) || rd_pending;
  assign load  = rd_pending && (!out_valid || payload_ch.ready);
  assign issue = (remaining != '0) && (!rd_pending || load);

  assign rd.en   = issue;
  assign rd.addr = rd_idx;
  assign payload_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= '0;
      rd_idx     <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (start.go) begin
        remaining <= start.len;
        rd_idx    <= '0;
      end else if (issue) begin
        remaining <= remaining - slcfr_pkg::LEN_W'(1);
        rd_idx    <= rd_idx + slcfr_pkg::ADDR_W'(1);
      end
      if (issue) begin
        rd_pending <= 1'b1;
      end else if (load) begin
        rd_pending <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (payload_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      data_idx  <= slcfr_pkg::IDX_W'(rd_idx);
      data_last <= (remaining == slcfr_pkg::LEN_W'(1));
    end
    if (load) begin
      payload_ch.payload_byte <= rdata;
      payload_ch.byte_index   <= data_idx;
      payload_ch.last_byte    <= data_last;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NOW(a_start_when_idle, start.go, !busy)
  `ASSERT_NOW(a_issue_has_work, issue, remaining != '0)
  `ASSERT_NEXT(a_issue_fills_stage, issue, rd_pending)

endmodule

// File: design/sync_length_crc8_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_crc8_frame_receiver_core
// Deframer for 0x55 0xAA / length / payload / CRC-8 frames.
// ----------------------------------------------------------------------------
// Received bytes enter one per cycle on byte_ch while byte_ch.ready is
// high. The parser hunts for the sync pair 0x55 0xAA, takes a length of 1
// to 64, writes that many payload bytes into a 64-entry synchronous buffer
// while updating a CRC-8 (poly 0x07, init 0, MSB first), then checks the
// CRC byte. A frame whose CRC matches and whose length equals
// expected_length is read back out of the buffer and sent on payload_ch one
// byte per transaction, with its index and last_byte on the final byte; any
// other frame is dropped silently. After a good CRC byte, ready stays low
// while the drain reads the buffer, which is one read per cycle on the
// single read port while payload_ch does not stall. The last byte sits in
// the output register, and input is taken again while it waits. Reads and
// writes to the buffer never overlap: the parser writes only while no drain
// is running. The buffer needs no clearing after reset; only entries
// written by the current frame are ever read. expected_length (reset 13) is
// written through cfg_wr_en / cfg_wr_data; the user must do so only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module sync_length_crc8_frame_receiver_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [slcfr_pkg::LEN_W-1:0] cfg_wr_data,
  slcfr_in_if.sink                    byte_ch,
  slcfr_out_if.source                 payload_ch
);

  logic [slcfr_pkg::LEN_W-1:0] expected_length;

  slcfr_pkg::slcfr_wr_t    wr;
  slcfr_pkg::slcfr_rd_t    rd;
  slcfr_pkg::slcfr_start_t start;
  logic [7:0]              rdata;
  logic                    drain_busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= slcfr_pkg::EXP_LEN_RESET;
    end else if (cfg_wr_en) begin
      expected_length <= cfg_wr_data;
    end
  end

  // front end: framing state, CRC, buffer writes
  slcfr_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .byte_ch         (byte_ch),
    .expected_length (expected_length),
    .drain_busy      (drain_busy),
    .wr              (wr),
    .start           (start)
  );

  // payload buffer
  slcfr_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  // back end: buffer read-out to payload_ch
  slcfr_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .rdata      (rdata),
    .rd         (rd),
    .busy       (drain_busy),
    .payload_ch (payload_ch)
  );

`include "assert_macros.svh"

  // write and read ports are interlocked through byte_ch.ready
  `ASSERT_NOW(a_no_rw_overlap, wr.en, !rd.en)

endmodule
